@@ src/avi_pkg.sv @@
`timescale 1ns / 1ps
package avi_pkg;
    localparam int unsigned ACC_W = 16;
    localparam int unsigned VEL_W = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_SQR,
        ST_ROOT,
        ST_KMH,
        ST_OUT
    } t_state;

    // per-lane filter control from the sequencer
    typedef struct packed {
        logic push;
        logic filling;
        logic hold;
        logic integ;
    } t_lane_ctl;
endpackage

@@ src/accel_to_velocity_integrator.sv @@
`timescale 1ns / 1ps
// A pair-closing sample gives its result after the squares, the bit-serial root
// and the km/h scaling; other samples give none.
// A new sample is accepted only once the last one is through; a new result holds
// the block in ST_OUT while an earlier result still waits on m_axis_tready.
// Reset (synchronous, active low) clears control, sums, counters and
// velocities; window memories are not cleared and fill over the first WINDOW samples.
module accel_to_velocity_integrator
    import avi_pkg::*;
#(
    parameter int unsigned WINDOW = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // accel_x[15:0], accel_y[31:16]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [127:0]          m_axis_tdata,  // vel_x, vel_y, speed_ms, speed_kmh
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int unsigned AW = $clog2(WINDOW);

    t_state r_state, n_state;
    logic [15:0] r_off_x, r_off_y;
    logic [14:0] r_dz;
    logic [7:0]  r_lim;
    logic [23:0] r_per;
    logic [AW:0] r_fill;
    logic [AW-1:0] r_ptr;
    logic        r_phase;
    logic [127:0] r_out;
    logic        r_ovalid;
    logic        r_sq_d, r_rs_d;
    t_lane_ctl   w_ctl;
    logic        w_take, w_done, w_sq, w_rs, w_kmh;
    logic signed [VEL_W-1:0] w_vx, w_vy;
    logic [VEL_W-1:0] w_speed, w_kmhv;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_take = s_axis_tvalid && s_axis_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
            r_dz    <= 15'd77;
            r_lim   <= 8'd25;
            r_per   <= 24'd83886;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OFFSET_X:   r_off_x <= i_cfg_data[15:0];
                REG_OFFSET_Y:   r_off_y <= i_cfg_data[15:0];
                REG_DEAD_ZONE:  r_dz    <= i_cfg_data[14:0];
                REG_ZERO_LIMIT: r_lim   <= i_cfg_data[7:0];
                REG_PERIOD:     r_per   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_take) n_state = ST_FILT;
            ST_FILT: begin
                if (r_fill >= (AW+1)'(WINDOW) && r_phase) n_state = ST_SQR;
                else n_state = ST_IDLE;
            end
            ST_SQR:  n_state = ST_ROOT;
            // done flag is stale until the new root has started
            ST_ROOT: if (w_done && !r_sq_d && !r_rs_d) n_state = ST_KMH;
            ST_KMH:  n_state = ST_OUT;
            ST_OUT:  if (!r_ovalid || m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_ctl = '0;
        w_sq = 1'b0;
        w_rs = 1'b0;
        w_kmh = 1'b0;
        unique case (r_state)
            ST_FILT: begin
                w_ctl.push    = 1'b1;
                w_ctl.filling = (r_fill < (AW+1)'(WINDOW));
                w_ctl.hold    = !w_ctl.filling && !r_phase;
            end
            ST_SQR:  w_ctl.integ = 1'b1;
            ST_ROOT: begin
                w_sq = !w_done && 1'b0;
            end
            default: ;
        endcase
        if (r_state == ST_SQR) w_rs = 1'b0;
        w_kmh = (r_state == ST_KMH);
    end

    // sequencer registers; square in the cycle after integrate, then root
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_ptr    <= '0;
            r_phase  <= 1'b0;
            r_ovalid <= 1'b0;
            r_sq_d   <= 1'b0;
            r_rs_d   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sq_d  <= (r_state == ST_SQR);
            r_rs_d  <= r_sq_d;
            if (r_state == ST_FILT) begin
                r_ptr <= (r_ptr == AW'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
                if (w_ctl.filling) r_fill <= r_fill + 1'b1;
                else r_phase <= !r_phase;
            end
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (r_state == ST_OUT && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
        end
    end

    avi_lane #(.WINDOW(WINDOW)) u_lane_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(w_take),
        .i_accel(s_axis_tdata[15:0]), .i_offset(r_off_x), .i_dead_zone(r_dz),
        .i_limit(r_lim), .i_period(r_per), .i_ptr(r_ptr), .i_ctl(w_ctl), .o_vel(w_vx)
    );
    avi_lane #(.WINDOW(WINDOW)) u_lane_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(w_take),
        .i_accel(s_axis_tdata[31:16]), .i_offset(r_off_y), .i_dead_zone(r_dz),
        .i_limit(r_lim), .i_period(r_per), .i_ptr(r_ptr), .i_ctl(w_ctl), .o_vel(w_vy)
    );

    avi_merge u_merge (
        .i_clk(i_clk), .i_sq(r_sq_d || w_sq), .i_root_start(r_rs_d || w_rs),
        .i_kmh(w_kmh), .i_vx(w_vx), .i_vy(w_vy), .o_root_done(w_done),
        .o_speed(w_speed), .o_kmh(w_kmhv)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_ovalid || m_axis_tready)) begin
            r_out <= {w_kmhv, w_speed, w_vy, w_vx};
        end
    end
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_out;
endmodule

@@ src/avi_ram.sv @@
`timescale 1ns / 1ps
module avi_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

@@ src/avi_lane.sv @@
`timescale 1ns / 1ps
// One axis: condition, moving average, pair hold, trapezoid integrate.
module avi_lane
    import avi_pkg::*;
#(
    parameter int unsigned WINDOW = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic signed [ACC_W-1:0] i_accel,
    input  logic signed [ACC_W-1:0] i_offset,
    input  logic [14:0]             i_dead_zone,
    input  logic [7:0]              i_limit,
    input  logic [23:0]             i_period,
    input  logic [$clog2(WINDOW)-1:0] i_ptr,
    input  t_lane_ctl               i_ctl,
    output logic signed [VEL_W-1:0] o_vel
);
    localparam int unsigned AW = $clog2(WINDOW);
    localparam int unsigned SW = ACC_W + $clog2(WINDOW + 1);
    // reciprocal of WINDOW, exact for any magnitude below 2^SW
    localparam int unsigned DIV_SH = SW + AW;
    localparam logic [DIV_SH-1:0] DIV_MUL =
        DIV_SH'(((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic signed [ACC_W-1:0] r_cond, n_cond;
    logic signed [SW-1:0]    r_sum;
    logic signed [ACC_W-1:0] r_held;
    logic signed [ACC_W-1:0] r_filt;
    logic [7:0]              r_zcnt;
    logic signed [VEL_W-1:0] r_vel;
    logic signed [ACC_W-1:0] w_old;
    logic signed [SW-1:0]    w_sum_new;
    logic signed [SW-1:0]    w_q;

    // saturate sample minus offset, then dead zone
    always_comb begin
        logic signed [ACC_W:0] c;
        logic [ACC_W:0] mag;
        c = {i_accel[ACC_W-1], i_accel} - {i_offset[ACC_W-1], i_offset};
        if (c > 17'sd32767) c = 17'sd32767;
        if (c < -17'sd32768) c = -17'sd32768;
        mag = c[ACC_W] ? 17'(-c) : 17'(c);
        n_cond = (mag <= {2'b0, i_dead_zone}) ? '0 : c[ACC_W-1:0];
    end

    avi_ram #(.WIDTH(ACC_W), .DEPTH(WINDOW)) u_win (
        .i_clk  (i_clk),
        .i_we   (i_ctl.push),
        .i_waddr(i_ptr),
        .i_wdata(r_cond),
        .i_raddr(i_ptr),
        .o_rdata(w_old)
    );

    // new sum and floor divide by WINDOW
    always_comb begin
        logic [SW-1:0]        mag;
        logic [SW+DIV_SH-1:0] prod;
        logic [SW-1:0]        qu;
        if (i_ctl.filling) begin
            w_sum_new = r_sum + SW'(r_cond);
        end else begin
            w_sum_new = r_sum - SW'(w_old) + SW'(r_cond);
        end
        // negative sums round their magnitude up, so the quotient floors
        mag = w_sum_new[SW-1] ? SW'(-w_sum_new) + SW'(WINDOW - 1) : w_sum_new;
        prod = (SW+DIV_SH)'(mag) * (SW+DIV_SH)'(DIV_MUL);
        qu = SW'(prod >> DIV_SH);
        w_q = w_sum_new[SW-1] ? -$signed(qu) : $signed(qu);
    end

    // trapezoid step
    logic w_both_zero;
    logic [7:0] w_zc;
    logic signed [VEL_W-1:0] w_vel_next;
    always_comb begin
        logic signed [ACC_W:0] s;
        logic signed [41:0] prod;
        logic signed [42:0] d;
        logic signed [33:0] nv;
        w_both_zero = (r_held == 0) && (r_filt == 0);
        w_zc = w_both_zero ? ((r_zcnt == 8'd255) ? r_zcnt : r_zcnt + 8'd1) : 8'd0;
        s = {r_held[ACC_W-1], r_held} + {r_filt[ACC_W-1], r_filt};
        prod = 42'(s) * $signed({18'd0, i_period});
        d = (43'(prod) + 43'sd65536) >>> 17;
        nv = 34'(r_vel) + 34'(d);
        if (nv > 34'sd2147483647) nv = 34'sd2147483647;
        if (nv < -34'sd2147483648) nv = -34'sd2147483648;
        w_vel_next = (w_zc >= i_limit) ? '0 : nv[VEL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_held <= '0;
            r_filt <= '0;
            r_zcnt <= '0;
            r_vel  <= '0;
        end else begin
            if (i_ctl.push) begin
                r_sum <= w_sum_new;
                r_filt <= ACC_W'(w_q);
                if (i_ctl.hold) r_held <= ACC_W'(w_q);
            end
            if (i_ctl.integ) begin
                r_zcnt <= w_zc;
                r_vel  <= w_vel_next;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_take) r_cond <= n_cond;
    end
    assign o_vel = r_vel;
endmodule

@@ src/avi_merge.sv @@
`timescale 1ns / 1ps
// Merges lane velocities: squares, bit-serial root, km/h scaling.
module avi_merge
    import avi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_sq,
    input  logic                    i_root_start,
    input  logic                    i_kmh,
    input  logic signed [VEL_W-1:0] i_vx,
    input  logic signed [VEL_W-1:0] i_vy,
    output logic                    o_root_done,
    output logic [VEL_W-1:0]        o_speed,
    output logic [VEL_W-1:0]        o_kmh
);
    logic [63:0] r_sqx, r_sqy;
    logic [64:0] r_rem;
    logic [64:0] r_n;
    logic [31:0] r_res;
    logic [5:0]  r_step;
    logic [31:0] r_kmh;
    logic        r_run;

    always_ff @(posedge i_clk) begin
        logic [66:0] trial;
        logic [66:0] rem2;
        logic [21:0] z;
        logic [44:0] m;
        logic [35:0] q;
        if (i_sq) begin
            r_sqx <= 64'(i_vx) * 64'(i_vx);
            r_sqy <= 64'(i_vy) * 64'(i_vy);
            r_run <= 1'b0;
        end
        if (i_root_start) begin
            r_n    <= {1'b0, r_sqx} + {1'b0, r_sqy};
            r_rem  <= '0;
            r_res  <= '0;
            r_step <= 6'd32;
            r_run  <= 1'b1;
        end else if (r_run && r_step != 0) begin
            // one result bit per cycle, two radicand bits
            rem2  = {r_rem, r_n[63:62]};
            trial = {33'd0, r_res, 2'b01};
            if (rem2 >= trial) begin
                r_rem <= 65'(rem2 - trial);
                r_res <= {r_res[30:0], 1'b1};
            end else begin
                r_rem <= 65'(rem2);
                r_res <= {r_res[30:0], 1'b0};
            end
            r_n    <= {r_n[62:0], 2'b00};
            r_step <= r_step - 6'd1;
        end
        if (i_kmh) begin
            // x*18/5 with x = xh*2^16 + xl and 2^16 = 5*13107 + 1:
            // 235926*xh + floor(18*(xh+xl)/5), small divide by reciprocal
            z = 22'({1'b0, r_res[31:16]} + {1'b0, r_res[15:0]}) * 22'd18;
            m = 45'(z) * 45'd6710887;
            q = 36'(r_res[31:16]) * 36'd235926 + 36'(m[44:25]);
            r_kmh <= (q > 36'h0FFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
        end
    end
    assign o_root_done = r_run && (r_step == 0);
    assign o_speed = r_res;
    assign o_kmh = r_kmh;
endmodule

@@ src/avi_checker.sv @@
`timescale 1ns / 1ps
module avi_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    // zero velocity gives zero speed
    a_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[63:0] == 64'd0 |-> m_axis_tdata[95:64] == 32'd0)
        else $error("speed nonzero for zero velocity");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
    a_kmh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[127:96] >= m_axis_tdata[95:64])
        else $error("km/h below m/s");
    // an accepted request makes the block busy, so ready drops
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after a request");
endmodule

bind accel_to_velocity_integrator avi_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench
    import avi_pkg::*;
();

    localparam int WIN = 20;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;   // accel_x[15:0], accel_y[31:16]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [127:0]          m_axis_tdata;        // vel_x, vel_y, speed_ms, speed_kmh
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    accel_to_velocity_integrator #(.WINDOW(WIN)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state and register copies
    int          m_off_x, m_off_y;
    int unsigned m_dead, m_limit, m_period;
    int          win_x[WIN], win_y[WIN];
    int          acc_sum_x, acc_sum_y;
    int          n_fill;
    bit          second_half;
    int          hold_x, hold_y;
    int unsigned zc_x, zc_y;
    int          v_x, v_y;

    logic [127:0] velocity_q[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    function automatic int clean_accel(int raw, int off);
        int c;
        c = raw - off;
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        return ((c < 0 ? -c : c) <= int'(m_dead)) ? 0 : c;
    endfunction

    function automatic int avg_floor(int s);
        if (s >= 0) return s / WIN;
        return -((-s + WIN - 1) / WIN);
    endfunction

    function automatic void trapezoid(input int a0, input int a1,
                                      inout int unsigned cnt, inout int vel);
        longint prod, nv;
        if (a0 == 0 && a1 == 0) begin
            if (cnt < 255) cnt++;
        end else begin
            cnt = 0;
        end
        if (cnt >= m_limit) begin
            vel = 0;
            return;
        end
        prod = longint'(a0 + a1) * longint'(m_period) + (64'sd1 <<< 16);
        nv = longint'(vel) + (prod >>> 17);   // arithmetic shift is floor
        if (nv > 64'sd2147483647) nv = 64'sd2147483647;
        if (nv < -64'sd2147483648) nv = -64'sd2147483648;
        vel = int'(nv);
    endfunction

    function automatic logic [31:0] root_floor(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r[31:0];
    endfunction

    function automatic void predict_velocity(logic [15:0] ax, logic [15:0] ay);
        int cx, cy, fx, fy;
        logic [63:0] sq, kmh;
        logic [31:0] spd;
        cx = clean_accel(int'($signed(ax)), m_off_x);
        cy = clean_accel(int'($signed(ay)), m_off_y);
        if (n_fill < WIN) begin
            win_x[n_fill] = cx;
            win_y[n_fill] = cy;
            acc_sum_x += cx;
            acc_sum_y += cy;
            n_fill++;
            return;
        end
        acc_sum_x += cx - win_x[0];
        acc_sum_y += cy - win_y[0];
        for (int i = 1; i < WIN; i++) begin
            win_x[i-1] = win_x[i];
            win_y[i-1] = win_y[i];
        end
        win_x[WIN-1] = cx;
        win_y[WIN-1] = cy;
        fx = avg_floor(acc_sum_x);
        fy = avg_floor(acc_sum_y);
        if (!second_half) begin
            hold_x = fx;
            hold_y = fy;
            second_half = 1;
            return;
        end
        second_half = 0;
        trapezoid(hold_x, fx, zc_x, v_x);
        trapezoid(hold_y, fy, zc_y, v_y);
        sq = 64'(longint'(v_x) * v_x) + 64'(longint'(v_y) * v_y);
        spd = root_floor(sq);
        kmh = (64'(spd) * 18) / 5;
        if (kmh > 64'hFFFF_FFFF) kmh = 64'hFFFF_FFFF;
        velocity_q.push_back({kmh[31:0], spd, v_y, v_x});
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        logic [127:0] exp_v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (velocity_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_axis_tdata);
            end else begin
                exp_v = velocity_q.pop_front();
                for (int f = 0; f < 4; f++) begin
                    if (m_axis_tdata[f*32 +: 32] !== exp_v[f*32 +: 32]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("field %0d: expected %h got %h", f,
                                     exp_v[f*32 +: 32], m_axis_tdata[f*32 +: 32]);
                    end
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // valid stays up after a request until the next one or an idle gap
    task automatic send_sample(logic [15:0] ax, logic [15:0] ay);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ay, ax};
        predict_velocity(ax, ay);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            REG_OFFSET_X:   m_off_x = int'($signed(val[15:0]));
            REG_OFFSET_Y:   m_off_y = int'($signed(val[15:0]));
            REG_DEAD_ZONE:  m_dead = 32'(val[14:0]);
            REG_ZERO_LIMIT: m_limit = 32'(val[7:0]);
            REG_PERIOD:     m_period = 32'(val[23:0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (velocity_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // pairs of extreme samples, including offsets that push past 16 bits
    task automatic test_directed();
        write_reg(REG_OFFSET_X, 32'h8000);
        write_reg(REG_OFFSET_Y, 32'h7FFF);
        write_reg(REG_DEAD_ZONE, 0);
        write_reg(REG_PERIOD, 24'hFFFFFF);
        for (int i = 0; i < WIN; i++)
            send_sample(i[0] ? 16'h7FFF : 16'h8000, i[0] ? 16'h8000 : 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h0000, 16'hFFFF);
        send_sample(16'hFFFF, 16'h0001);
        send_sample(16'h8000, 16'h7FFF);
        wait_idle();
    endtask

    // dead zone drives mostly zero pairs so the zero limit can clear the velocity
    task automatic test_zero_clear(int unsigned lim, int unsigned dz);
        write_reg(REG_OFFSET_X, 0);
        write_reg(REG_OFFSET_Y, 0);
        write_reg(REG_ZERO_LIMIT, lim);
        write_reg(REG_DEAD_ZONE, dz);
        write_reg(REG_PERIOD, 1);
        for (int i = 0; i < 60; i++)
            send_sample(16'($urandom_range(2 * dz + 1) - dz), 16'($urandom_range(200) - 100));
        wait_idle();
    endtask

    task automatic test_random(int n);
        logic [15:0] ax, ay;
        for (int i = 0; i < n; i++) begin
            ax = 16'($urandom());
            ay = 16'($urandom());
            if ($urandom_range(3) == 0) begin
                ax = 16'($signed(ax) >>> 8);
                ay = 16'($signed(ay) >>> 8);
            end
            send_sample(ax, ay);
        end
        wait_idle();
    endtask

    initial begin
        m_off_x = 0; m_off_y = 0; m_dead = 77; m_limit = 25; m_period = 83886;
        acc_sum_x = 0; acc_sum_y = 0; n_fill = 0; second_half = 0;
        hold_x = 0; hold_y = 0; zc_x = 0; zc_y = 0; v_x = 0; v_y = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 10;
        recv_stall_pct = 61;
        test_directed();
        test_zero_clear(255, 32767);
        test_zero_clear(1, 300);
        write_reg(REG_ZERO_LIMIT, 25);
        write_reg(REG_PERIOD, 83886);
        write_reg(REG_DEAD_ZONE, 77);
        test_random(300);

        send_idle_pct = 61;
        recv_stall_pct = 10;
        write_reg(REG_OFFSET_X, $urandom());
        write_reg(REG_OFFSET_Y, $urandom());
        write_reg(REG_PERIOD, 24'hFFFFFF);
        test_random(300);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(REG_OFFSET_X, 16'h7FFF);
        write_reg(REG_OFFSET_Y, 16'h8000);
        write_reg(REG_DEAD_ZONE, 32767);
        write_reg(REG_ZERO_LIMIT, 1);
        test_random(100);
        write_reg(REG_OFFSET_X, 0);
        write_reg(REG_OFFSET_Y, 0);
        write_reg(REG_DEAD_ZONE, 0);
        write_reg(REG_ZERO_LIMIT, 255);
        write_reg(REG_PERIOD, $urandom_range(24'hFFFFFF, 1));
        test_random(150);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ accel_to_velocity_integrator.f @@
src/avi_pkg.sv
src/avi_ram.sv
src/avi_lane.sv
src/avi_merge.sv
src/accel_to_velocity_integrator.sv
src/avi_checker.sv
tb/testbench.sv
